[rtl/core/srfb_pkg.sv]
package srfb_pkg;

	// CRC-16 constants, MSB first
	localparam logic [15:0] CrcPoly = 16'h1021;
	localparam logic [15:0] CrcInit = 16'hB5D2;

	// preamble byte sent ahead of a three-byte address
	localparam logic [7:0] Preamble = 8'h55;

	// longest payload of one packet
	localparam logic [4:0] MaxPayload = 5'd26;

	// address length limits
	localparam logic [2:0] AddrLenMin = 3'd3;
	localparam logic [2:0] AddrLenMax = 3'd5;

	// input item kinds
	localparam logic OpByte  = 1'b0;
	localparam logic OpEmpty = 1'b1;

	localparam int unsigned ScrambleLen = 35;
	localparam int unsigned CrcTabLen   = 28;

	localparam logic [7:0] ScrambleTab [ScrambleLen] = '{
		8'hE3, 8'hB1, 8'h4B, 8'hEA, 8'h85, 8'hBC, 8'hE5, 8'h66,
		8'h0D, 8'hAE, 8'h8C, 8'h88, 8'h12, 8'h69, 8'hEE, 8'h1F,
		8'hC7, 8'h62, 8'h97, 8'hD5, 8'h0B, 8'h79, 8'hCA, 8'hCC,
		8'h1B, 8'h5D, 8'h19, 8'h10, 8'h24, 8'hD3, 8'hDC, 8'h3F,
		8'h8E, 8'hC5, 8'h2F
	};

	localparam logic [15:0] CrcOutTab [CrcTabLen] = '{
		16'h0000, 16'h3448, 16'h9BA7, 16'h8BBB, 16'h85E1, 16'h3E8C,
		16'h451E, 16'h18E6, 16'h6B24, 16'hE7AB, 16'h3828, 16'h814B,
		16'hD461, 16'hF494, 16'h2503, 16'h691D, 16'hFE8B, 16'h9BA7,
		16'h8B17, 16'h2920, 16'h8B5F, 16'h61B1, 16'hD391, 16'h7401,
		16'h2138, 16'h129F, 16'hB3A0, 16'h2988
	};

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_ADDR_LEN   = 2'd0,
		REG_TX_ADDRESS = 2'd1,
		REG_CRC_ENABLE = 2'd2
	} reg_idx_t;

	// back end byte sequencer phases
	typedef enum logic [2:0] {
		PH_PRE,
		PH_ADDR,
		PH_PAY,
		PH_CRCH,
		PH_CRCL,
		PH_DONE
	} phase_t;

	// live configuration, address length already clamped
	typedef struct packed {
		logic [2:0]  alen;
		logic [39:0] addr;
		logic        crc_en;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic       hdr;      // header goes out first
		logic       keep;     // payload byte kept
		logic       close;    // item ends the packet
		logic       crc;      // CRC appended on close
		logic       ovf;      // bytes dropped in this packet so far
		logic [7:0] data;     // scrambled payload byte
		logic [4:0] crc_idx;  // CRC whitening entry
	} cmd_t;

	// one frame beat
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       trunc;
	} res_t;

	function automatic logic [7:0] scramble(input logic [5:0] idx);
		logic [7:0] r;
		r = 8'h00;
		if (idx < 6'(ScrambleLen)) begin
			r = ScrambleTab[idx];
		end
		return r;
	endfunction

	function automatic logic [15:0] crc_whiten(input logic [4:0] idx);
		logic [15:0] r;
		r = 16'h0000;
		if (idx < 5'(CrcTabLen)) begin
			r = CrcOutTab[idx];
		end
		return r;
	endfunction

	function automatic logic [15:0] crc_feed(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [7:0] rev8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = b[7 - i];
		end
		return r;
	endfunction

	function automatic logic [2:0] clamp_alen(input logic [2:0] v);
		logic [2:0] r;
		r = v;
		if (v < AddrLenMin) begin
			r = AddrLenMin;
		end else if (v > AddrLenMax) begin
			r = AddrLenMax;
		end
		return r;
	endfunction

endpackage

[rtl/core/scrambled_radio_frame_builder.sv]
// Channel   Direction  Handshake          Beat
// input     in         push / full        op, payload_byte, last
// result    out        pop / empty        frame_byte, frame_last, truncated
// config    in         wr_en              wr_index, wr_data
//
// The byte sequencer emits frame beats in turn, so payload bytes of an open packet
// stream at one per cycle while the result queue has room. The first item of a packet
// adds one beat per address byte plus the preamble for a three-byte address; a close
// with CRC adds two. An item with no beat is popped even if the result queue is full.
// Items wait in the command queue and beats in the result queue; reset clears both.
// A full result queue stalls the back end; the command queue absorbs input meanwhile.
module scrambled_radio_frame_builder import srfb_pkg::*; #(
	parameter int unsigned CMD_DEPTH = 4,
	parameter int unsigned RES_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        op,
	input  logic [7:0]  payload_byte,
	input  logic        last,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  frame_byte,
	output logic        frame_last,
	output logic        truncated,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [39:0] wr_data
);

	localparam int unsigned CmdW = $bits(cmd_t);
	localparam int unsigned ResW = $bits(res_t);

	logic [2:0]  addr_len_q;
	logic [39:0] tx_address_q;
	logic        crc_enable_q;

	cfg_t            cfg;
	logic            cq_push;
	cmd_t            cq_in;
	logic            cq_full;
	logic            cq_pop;
	logic            cq_empty;
	logic [CmdW-1:0] cq_out;
	logic            rq_push;
	res_t            rq_in;
	logic            rq_full;
	logic [ResW-1:0] rq_out;
	res_t            res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_len_q   <= 3'd5;
			tx_address_q <= '0;
			crc_enable_q <= 1'b1;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_ADDR_LEN:   addr_len_q   <= wr_data[2:0];
				REG_TX_ADDRESS: tx_address_q <= wr_data;
				REG_CRC_ENABLE: crc_enable_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.alen   = clamp_alen(addr_len_q);
		cfg.addr   = tx_address_q;
		cfg.crc_en = crc_enable_q;
	end

	assign full = cq_full;

	srfb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.push         (push),
		.op           (op),
		.payload_byte (payload_byte),
		.last         (last),
		.q_full       (cq_full),
		.q_push       (cq_push),
		.q_cmd        (cq_in)
	);

	srfb_fifo #(
		.WIDTH (CmdW),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cq_push),
		.din    (CmdW'(cq_in)),
		.full   (cq_full),
		.pop    (cq_pop),
		.dout   (cq_out),
		.empty  (cq_empty)
	);

	srfb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_valid (~cq_empty),
		.cmd     (cmd_t'(cq_out)),
		.q_pop   (cq_pop),
		.o_full  (rq_full),
		.o_push  (rq_push),
		.o_res   (rq_in)
	);

	srfb_fifo #(
		.WIDTH (ResW),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.din    (ResW'(rq_in)),
		.full   (rq_full),
		.pop    (pop),
		.dout   (rq_out),
		.empty  (empty)
	);

	assign res        = res_t'(rq_out);
	assign frame_byte = res.data;
	assign frame_last = res.last;
	assign truncated  = res.trunc;

endmodule

[rtl/core/srfb_fifo.sv]
module srfb_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = mem_q[rptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// storage, no reset
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= din;
		end
	end

endmodule

[rtl/core/srfb_front.sv]
module srfb_front import srfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       push,
	input  logic       op,
	input  logic [7:0] payload_byte,
	input  logic       last,
	input  logic       q_full,
	output logic       q_push,
	output cmd_t       q_cmd
);

	logic       in_packet_q;
	logic [4:0] count_q;
	logic       ovf_q;

	logic [4:0] cap;
	logic [4:0] room;
	logic       keep;
	logic       close;
	logic [4:0] count_nx;
	logic       ovf_nx;
	logic [5:0] crc_sum;
	logic [5:0] scr_idx;

	assign q_push = push & ~q_full;

	// payload cap: min(MaxPayload, 30 - address length)
	assign room = 5'd30 - 5'(cfg.alen);
	assign cap  = (room > MaxPayload) ? MaxPayload : room;

	// classify the beat
	assign keep     = (op == OpByte) & (count_q < cap);
	assign close    = (op == OpEmpty) | last;
	assign count_nx = count_q + 5'(keep);
	assign ovf_nx   = ovf_q | ((op == OpByte) & ~keep);
	assign scr_idx  = 6'(cfg.alen) + 6'(count_q);
	assign crc_sum  = 6'(cfg.alen) - 6'(AddrLenMin) + 6'(count_nx);

	always_comb begin
		q_cmd.hdr     = ~in_packet_q;
		q_cmd.keep    = keep;
		q_cmd.close   = close;
		q_cmd.crc     = close & cfg.crc_en;
		q_cmd.ovf     = ovf_nx;
		q_cmd.data    = rev8(payload_byte) ^ scramble(scr_idx);
		q_cmd.crc_idx = (crc_sum > 6'(CrcTabLen - 1)) ? 5'(CrcTabLen - 1) : crc_sum[4:0];
	end

	// packet tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
		end else if (q_push) begin
			if (close) begin
				in_packet_q <= 1'b0;
				count_q     <= '0;
				ovf_q       <= 1'b0;
			end else begin
				in_packet_q <= 1'b1;
				count_q     <= count_nx;
				ovf_q       <= ovf_nx;
			end
		end
	end

endmodule

[rtl/core/srfb_back.sv]
module srfb_back import srfb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic q_valid,
	input  cmd_t cmd,
	output logic q_pop,
	input  logic o_full,
	output logic o_push,
	output res_t o_res
);

	logic        started_q;
	phase_t      phase_q;
	logic [2:0]  idx_q;
	logic [15:0] crc_q;

	phase_t      cur_phase;
	logic [2:0]  cur_idx;
	phase_t      nxt_phase;
	logic [2:0]  nxt_idx;
	phase_t      after_hdr;
	phase_t      after_pay;
	logic        adv;
	logic        feed;
	logic [2:0]  addr_k;
	logic [7:0]  addr_byte;
	logic [15:0] crc_out;
	logic [15:0] crc_upd;

	// what follows the address and the payload byte
	assign after_pay = cmd.crc ? PH_CRCH : PH_DONE;
	assign after_hdr = cmd.keep ? PH_PAY : after_pay;

	// phase of the head item this cycle
	always_comb begin
		if (started_q) begin
			cur_phase = phase_q;
			cur_idx   = idx_q;
		end else begin
			cur_idx = '0;
			if (cmd.hdr) begin
				cur_phase = (cfg.alen == AddrLenMin) ? PH_PRE : PH_ADDR;
			end else begin
				cur_phase = after_hdr;
			end
		end
	end

	// next state
	always_comb begin
		nxt_idx = cur_idx;
		unique case (cur_phase)
			PH_PRE: begin
				nxt_phase = PH_ADDR;
				nxt_idx   = '0;
			end
			PH_ADDR: begin
				if (cur_idx == cfg.alen - 3'd1) begin
					nxt_phase = after_hdr;
				end else begin
					nxt_phase = PH_ADDR;
					nxt_idx   = cur_idx + 3'd1;
				end
			end
			PH_PAY:  nxt_phase = after_pay;
			PH_CRCH: nxt_phase = PH_CRCL;
			PH_CRCL: nxt_phase = PH_DONE;
			default: nxt_phase = PH_DONE;
		endcase
	end

	// address byte, last byte first
	assign addr_k    = cfg.alen - 3'd1 - cur_idx;
	assign addr_byte = 8'(cfg.addr >> {addr_k, 3'b000});
	assign crc_out   = crc_q ^ crc_whiten(cmd.crc_idx);

	// outputs
	always_comb begin
		o_res.data = 8'h00;
		feed       = 1'b0;
		unique case (cur_phase)
			PH_PRE:  o_res.data = Preamble;
			PH_ADDR: begin
				o_res.data = addr_byte ^ scramble(6'(cur_idx));
				feed       = 1'b1;
			end
			PH_PAY: begin
				o_res.data = cmd.data;
				feed       = 1'b1;
			end
			PH_CRCH: o_res.data = crc_out[15:8];
			PH_CRCL: o_res.data = crc_out[7:0];
			default: o_res.data = 8'h00;
		endcase
		o_res.last  = cmd.close & (nxt_phase == PH_DONE);
		o_res.trunc = cmd.close & (nxt_phase == PH_DONE) & cmd.ovf;
		adv         = q_valid & ((cur_phase == PH_DONE) | ~o_full);
		o_push      = q_valid & (cur_phase != PH_DONE) & ~o_full;
		q_pop       = adv & (nxt_phase == PH_DONE);
		crc_upd     = feed ? crc_feed(crc_q, o_res.data) : crc_q;
	end

	// sequencer and running CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			phase_q   <= PH_DONE;
			idx_q     <= '0;
			crc_q     <= CrcInit;
		end else if (adv) begin
			if (nxt_phase == PH_DONE) begin
				started_q <= 1'b0;
				crc_q     <= cmd.close ? CrcInit : crc_upd;
			end else begin
				started_q <= 1'b1;
				phase_q   <= nxt_phase;
				idx_q     <= nxt_idx;
				crc_q     <= crc_upd;
			end
		end
	end

endmodule

[rtl/core/srfb_checker.sv]
module srfb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  frame_byte,
	input logic        frame_last,
	input logic        truncated
);

	// truncation is only flagged on the closing beat
	a_trunc_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && truncated) |-> frame_last)
		else $error("truncated without frame_last");

	// a waiting beat holds until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(frame_byte) && $stable(frame_last)
			&& $stable(truncated)))
		else $error("result beat changed while stalled");

	// right after reset nothing waits on the result side and the input side is not full
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> (empty && !full))
		else $error("queues not clear after reset");

endmodule

bind scrambled_radio_frame_builder srfb_checker u_srfb_checker (.*);
